// ===== src/sme_pkg.sv =====
`timescale 1ns / 1ps
package sme_pkg;
    localparam int WORD_BITS = 64;
    localparam int CNT_BITS  = $clog2(WORD_BITS + 1);

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_MOD = 2'd1;
    localparam logic [1:0] ST_NOT_INV  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_RDIV, S_RESID, S_ITEST, S_IDIV, S_IMUL, S_IUPD,
        S_PTEST, S_PM1, S_PSQ, S_PM2, S_FIN
    } t_state;

    typedef enum logic [1:0] { MS_QCS, MS_ACCB, MS_BB } t_msel;
    typedef enum logic { DS_BASE, DS_INV } t_dsel;

    typedef struct packed {
        logic       load;
        logic       div_start;
        t_dsel      div_sel;
        logic       mul_start;
        t_msel      mul_sel;
        logic       resid_wr;
        logic       inv_init;
        logic       inv_upd;
        logic       inv_fin;
        logic       pow_init;
        logic       acc_wr;
        logic       b_wr;
        logic       e_shift;
        logic       out_wr;
        logic       out_zero;
        logic [1:0] code;
    } t_cmd;

    typedef struct packed {
        logic mod_zero;
        logic m_one;
        logic expo_neg;
        logic div_busy;
        logic mul_busy;
        logic cr_zero;
        logic pr_one;
        logic e_zero;
        logic e_lsb;
        logic e_next_zero;
    } t_stat;
endpackage

// ===== src/signed_modular_exponentiation_core.sv =====
`timescale 1ns / 1ps
// Computes base^exponent mod |modulus| on signed 64-bit words, the result taking the sign of
// the modulus; status 1 flags a zero modulus and status 2 a base with no inverse for a
// negative exponent. One word is in flight at a time: a residue divide, then for a negative
// exponent up to about 92 Euclid rounds, each a divide plus a bit-serial multiply, then a
// power loop of up to 125 modular multiplies, up to a multiply and a square per exponent
// bit. The shared restoring divider and the add-and-double multiplier work one bit per cycle
// each. A finished result waits in the output register while the next word is taken.
module signed_modular_exponentiation_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [sme_pkg::WORD_BITS-1:0]  i_base,
    input  logic signed [sme_pkg::WORD_BITS-1:0]  i_exponent,
    input  logic signed [sme_pkg::WORD_BITS-1:0]  i_modulus,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [sme_pkg::WORD_BITS-1:0]  o_result,
    output logic [1:0]                            o_status
);
    import sme_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    sme_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    sme_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_base     (i_base),
        .i_exponent (i_exponent),
        .i_modulus  (i_modulus),
        .o_result   (o_result),
        .o_status   (o_status)
    );
endmodule

// ===== src/sme_datapath.sv =====
`timescale 1ns / 1ps
module sme_datapath (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  sme_pkg::t_cmd                         i_cmd,
    output sme_pkg::t_stat                        o_stat,
    input  logic signed [sme_pkg::WORD_BITS-1:0]  i_base,
    input  logic signed [sme_pkg::WORD_BITS-1:0]  i_exponent,
    input  logic signed [sme_pkg::WORD_BITS-1:0]  i_modulus,
    output logic signed [sme_pkg::WORD_BITS-1:0]  o_result,
    output logic [1:0]                            o_status
);
    import sme_pkg::*;
    localparam int W = WORD_BITS;

    logic [W-1:0] r_base, r_expo, r_m, r_b, r_e, r_acc;
    logic         r_mneg;
    logic [W-1:0] r_pr, r_cr, r_ps, r_cs;
    logic [W-1:0] r_drem, r_dq, r_dd;
    logic [CNT_BITS-1:0] r_dcnt;
    logic [W-1:0] r_mx, r_my, r_macc;
    logic signed [W-1:0] r_result;
    logic [1:0]   r_status;

    logic [W:0]   w_sh, w_sub;
    logic [W:0]   w_s1, w_s2;
    logic [W-1:0] w_add1, w_add2;
    logic [W-1:0] w_mx0, w_my0, w_qs, w_ns, w_resid, w_babs, w_eabs;

    assign w_babs = r_base[W-1] ? ('0 - r_base) : r_base;
    assign w_eabs = r_expo[W-1] ? ('0 - r_expo) : r_expo;

    // restoring divider step
    assign w_sh  = {r_drem, r_dq[W-1]};
    assign w_sub = w_sh - {1'b0, r_dd};

    // add-and-double step
    assign w_s1   = {1'b0, r_macc} + {1'b0, r_mx};
    assign w_add1 = (w_s1 >= {1'b0, r_m}) ? W'(w_s1 - {1'b0, r_m}) : w_s1[W-1:0];
    assign w_s2   = {1'b0, r_mx} + {1'b0, r_mx};
    assign w_add2 = (w_s2 >= {1'b0, r_m}) ? W'(w_s2 - {1'b0, r_m}) : w_s2[W-1:0];

    always_comb begin
        unique case (i_cmd.mul_sel)
            MS_QCS:  begin w_mx0 = r_dq;  w_my0 = r_cs; end
            MS_ACCB: begin w_mx0 = r_acc; w_my0 = r_b;  end
            default: begin w_mx0 = r_b;   w_my0 = r_b;  end
        endcase
    end

    assign w_qs    = r_macc;
    assign w_ns    = (r_ps >= w_qs) ? (r_ps - w_qs) : (r_ps + (r_m - w_qs));
    assign w_resid = (r_base[W-1] && r_drem != '0) ? (r_m - r_drem) : r_drem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
            r_my   <= '0;
        end else begin
            if (i_cmd.div_start) begin
                r_dcnt <= CNT_BITS'(W);
                r_drem <= '0;
                if (i_cmd.div_sel == DS_BASE) begin
                    r_dq <= w_babs;
                    r_dd <= r_m;
                end else begin
                    r_dq <= r_pr;
                    r_dd <= r_cr;
                end
            end else if (r_dcnt != '0) begin
                r_dcnt <= r_dcnt - 1'b1;
                if (!w_sub[W]) begin
                    r_drem <= w_sub[W-1:0];
                    r_dq   <= {r_dq[W-2:0], 1'b1};
                end else begin
                    r_drem <= w_sh[W-1:0];
                    r_dq   <= {r_dq[W-2:0], 1'b0};
                end
            end
            if (i_cmd.mul_start) begin
                r_mx   <= (w_mx0 >= r_m) ? (w_mx0 - r_m) : w_mx0;
                r_my   <= w_my0;
                r_macc <= '0;
            end else if (r_my != '0) begin
                if (r_my[0]) r_macc <= w_add1;
                r_mx <= w_add2;
                r_my <= r_my >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_base <= i_base;
            r_expo <= i_exponent;
            r_mneg <= i_modulus[W-1];
            r_m    <= i_modulus[W-1] ? ('0 - i_modulus) : i_modulus;
        end
        if (i_cmd.resid_wr) r_b <= w_resid;
        if (i_cmd.inv_init) begin
            r_pr <= w_resid;
            r_cr <= r_m;
            r_ps <= W'(1);
            r_cs <= '0;
        end
        if (i_cmd.inv_upd) begin
            r_pr <= r_cr;
            r_cr <= r_drem;
            r_ps <= r_cs;
            r_cs <= w_ns;
        end
        if (i_cmd.inv_fin) r_b <= r_ps;
        if (i_cmd.pow_init) begin
            r_e   <= w_eabs;
            r_acc <= W'(1);
        end
        if (i_cmd.acc_wr)  r_acc <= r_macc;
        if (i_cmd.b_wr)    r_b   <= r_macc;
        if (i_cmd.e_shift) r_e   <= r_e >> 1;
        if (i_cmd.out_wr) begin
            r_status <= i_cmd.code;
            if (i_cmd.code != ST_OK || i_cmd.out_zero) r_result <= '0;
            else if (r_mneg && r_acc != '0)           r_result <= r_acc - r_m;
            else                                       r_result <= r_acc;
        end
    end

    assign o_stat.mod_zero    = (r_m == '0);
    assign o_stat.m_one       = (r_m == W'(1));
    assign o_stat.expo_neg    = r_expo[W-1];
    assign o_stat.div_busy    = (r_dcnt != '0);
    assign o_stat.mul_busy    = (r_my != '0);
    assign o_stat.cr_zero     = (r_cr == '0);
    assign o_stat.pr_one      = (r_pr == W'(1));
    assign o_stat.e_zero      = (r_e == '0);
    assign o_stat.e_lsb       = r_e[0];
    assign o_stat.e_next_zero = ((r_e >> 1) == '0);

    assign o_result = r_result;
    assign o_status = r_status;
endmodule

// ===== src/sme_ctrl.sv =====
`timescale 1ns / 1ps
module sme_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    input  sme_pkg::t_stat i_stat,
    output sme_pkg::t_cmd  o_cmd
);
    import sme_pkg::*;

    t_state     r_state, n_state;
    logic [1:0] r_code, n_code;
    logic       r_zero, n_zero;
    logic       r_out_valid;
    logic       w_out_free;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        n_zero  = r_zero;
        unique case (r_state)
            S_IDLE: if (i_in_valid) begin
                n_state = S_CHECK;
                n_code  = ST_OK;
                n_zero  = 1'b0;
            end
            S_CHECK: begin
                if (i_stat.mod_zero) begin
                    n_state = S_FIN;
                    n_code  = ST_ZERO_MOD;
                end else if (i_stat.m_one) begin
                    n_state = S_FIN;
                    n_zero  = 1'b1;
                end else begin
                    n_state = S_RDIV;
                end
            end
            S_RDIV:  if (!i_stat.div_busy) n_state = S_RESID;
            S_RESID: n_state = i_stat.expo_neg ? S_ITEST : S_PTEST;
            S_ITEST: begin
                if (!i_stat.cr_zero) begin
                    n_state = S_IDIV;
                end else if (i_stat.pr_one) begin
                    n_state = S_PTEST;
                end else begin
                    n_state = S_FIN;
                    n_code  = ST_NOT_INV;
                end
            end
            S_IDIV:  if (!i_stat.div_busy) n_state = S_IMUL;
            S_IMUL:  if (!i_stat.mul_busy) n_state = S_IUPD;
            S_IUPD:  n_state = S_ITEST;
            S_PTEST: begin
                if (i_stat.e_zero)     n_state = S_FIN;
                else if (i_stat.e_lsb) n_state = S_PM1;
                else                   n_state = S_PSQ;
            end
            S_PM1:   if (!i_stat.mul_busy) n_state = S_PSQ;
            S_PSQ:   n_state = i_stat.e_next_zero ? S_FIN : S_PM2;
            S_PM2:   if (!i_stat.mul_busy) n_state = S_PTEST;
            S_FIN:   if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.div_sel  = DS_BASE;
        o_cmd.mul_sel  = MS_QCS;
        o_cmd.code     = r_code;
        o_cmd.out_zero = r_zero;
        unique case (r_state)
            S_IDLE:  o_cmd.load = i_in_valid;
            S_CHECK: o_cmd.div_start = !i_stat.mod_zero && !i_stat.m_one;
            S_RESID: o_cmd.resid_wr = 1'b1;
            S_ITEST: begin
                if (!i_stat.cr_zero) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DS_INV;
                end else if (i_stat.pr_one) begin
                    o_cmd.inv_fin  = 1'b1;
                    o_cmd.pow_init = 1'b1;
                end
            end
            S_IDIV: if (!i_stat.div_busy) begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = MS_QCS;
            end
            S_IUPD: o_cmd.inv_upd = 1'b1;
            S_PTEST: if (!i_stat.e_zero && i_stat.e_lsb) begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = MS_ACCB;
            end
            S_PM1: o_cmd.acc_wr = !i_stat.mul_busy;
            S_PSQ: begin
                o_cmd.e_shift = 1'b1;
                if (!i_stat.e_next_zero) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_sel   = MS_BB;
                end
            end
            S_PM2: o_cmd.b_wr = !i_stat.mul_busy;
            S_FIN: o_cmd.out_wr = w_out_free;
            default: o_cmd.load = 1'b0;
        endcase
        // non-negative exponent path enters the power loop straight from residue
        if (r_state == S_RESID && !i_stat.expo_neg) o_cmd.pow_init = 1'b1;
        if (r_state == S_RESID && i_stat.expo_neg)  o_cmd.inv_init = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_code      <= ST_OK;
            r_zero      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
            r_zero  <= n_zero;
            if (o_cmd.out_wr)      r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_wr |-> w_out_free) else $error("result word overwritten");
    a_mul_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.mul_start |-> !i_stat.mul_busy) else $error("mul started while busy");
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |-> !i_stat.div_busy) else $error("div started while busy");
    a_out_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_wr |=> r_out_valid) else $error("result word not presented");
endmodule
